@@ hw/rtl/csem_pkg.sv @@
// Shared types and constants for the counting semaphore table unit.
// No dependencies; used by every module of the block.
`default_nettype none

package csem_pkg;

  // Default sizing of the bank
  localparam int NUM_SEMAPHORES_DEF = 32;
  localparam int COUNT_WIDTH_DEF    = 16;

  // Fixed field widths of the request and result
  localparam int MODE_W   = 2;
  localparam int ID_W     = 8;
  localparam int INIT_W   = 16;
  localparam int STATUS_W = 3;
  localparam int RET_W    = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_INIT    = 2'd0,
    MODE_DESTROY = 2'd1,
    MODE_WAIT    = 2'd2,
    MODE_SIGNAL  = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_ID   = 3'd1,
    ST_ACTIVE   = 3'd2,
    ST_INACTIVE = 3'd3,
    ST_BLOCK    = 3'd4,
    ST_CEILING  = 3'd5
  } status_e;

  // One registered request
  typedef struct packed {
    mode_e             mode;
    logic [ID_W-1:0]   sem_id;
    logic [INIT_W-1:0] init_count;
  } req_t;

  // One result
  typedef struct packed {
    status_e          status;
    logic [RET_W-1:0] ret_id;
    logic             wake;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/counting_semaphore_table_unit.sv @@
// Top level of the counting semaphore table unit.
// Depends on csem_pkg, csem_in_stage, csem_table and csem_out_stage.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------
//   request  | in_valid_i / in_stall_o | mode_i, sem_id_i, initial_count_i
//   result   | out_valid_o / out_stall_i | status_o, ret_id_o, wake_o
//
// One request per cycle sustained while the result side is not stalled; a
// request passes the input register, then the table lookup and update into
// the result register.
// The table does the entry read-modify-write combinationally between the registers.
// Reset clears all active marks at once; no clearing pass is needed.
// A stalled result holds the request register, which then stalls the input.
`default_nettype none

module counting_semaphore_table_unit #(
  parameter int NUM_SEMAPHORES = csem_pkg::NUM_SEMAPHORES_DEF,
  parameter int COUNT_WIDTH    = csem_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [csem_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [csem_pkg::ID_W-1:0]     sem_id_i,
  input  wire logic [csem_pkg::INIT_W-1:0]   initial_count_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [csem_pkg::STATUS_W-1:0]      status_o,
  output logic [csem_pkg::RET_W-1:0]         ret_id_o,
  output logic                               wake_o
);

  logic           advance;
  logic           req_valid;
  logic           commit;
  csem_pkg::req_t req;
  csem_pkg::res_t res;

  assign commit = req_valid && advance;

  csem_in_stage u_in (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .sem_id_i        (sem_id_i),
    .initial_count_i (initial_count_i),
    .advance_i       (advance),
    .req_valid_o     (req_valid),
    .req_o           (req)
  );

  csem_table #(
    .NUM_SEMAPHORES (NUM_SEMAPHORES),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (commit),
    .req_i    (req),
    .res_o    (res)
  );

  csem_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (commit),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .ret_id_o    (ret_id_o),
    .wake_o      (wake_o)
  );

  // wake only accompanies an ok status with a zero echoed id
  a_wake_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && wake_o |-> status_o == csem_pkg::ST_OK && ret_id_o == '0)
    else $error("wake with non-ok status");

  // rejected requests never echo an id
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != csem_pkg::ST_OK |-> ret_id_o == '0 && !wake_o)
    else $error("rejected request echoed id or wake");

  // input is only held back while a request sits behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

@@ hw/rtl/csem_in_stage.sv @@
// Request input register with stall generation.
// Depends on csem_pkg for the request type.
`default_nettype none

module csem_in_stage (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [csem_pkg::MODE_W-1:0] mode_i,
  input  wire logic [csem_pkg::ID_W-1:0]   sem_id_i,
  input  wire logic [csem_pkg::INIT_W-1:0] initial_count_i,
  input  wire logic                        advance_i,
  output logic                             req_valid_o,
  output csem_pkg::req_t                   req_o
);

  logic           valid_q, valid_d;
  csem_pkg::req_t req_q;
  logic           load;

  // Hold while a request waits and the table cannot take it
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q.mode       <= csem_pkg::mode_e'(mode_i);
      req_q.sem_id     <= sem_id_i;
      req_q.init_count <= initial_count_i;
    end
  end

  assign req_valid_o = valid_q;
  assign req_o       = req_q;

endmodule

`default_nettype wire

@@ hw/rtl/csem_table.sv @@
// Semaphore state (active marks, counts, ceilings) and the per-request decision.
// Depends on csem_pkg for request, result, mode and status types.
`default_nettype none

module csem_table #(
  parameter int NUM_SEMAPHORES = csem_pkg::NUM_SEMAPHORES_DEF,
  parameter int COUNT_WIDTH    = csem_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          commit_i,
  input  wire csem_pkg::req_t req_i,
  output csem_pkg::res_t     res_o
);

  localparam int IdxW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;

  logic [NUM_SEMAPHORES-1:0] active_q;
  logic [COUNT_WIDTH-1:0]    count_q   [NUM_SEMAPHORES];
  logic [COUNT_WIDTH-1:0]    ceiling_q [NUM_SEMAPHORES];

  logic [IdxW-1:0]        idx;
  logic                   bad_id;
  logic                   act_cur;
  logic [COUNT_WIDTH-1:0] cnt_cur, ceil_cur, init_val;
  logic                   wr_act, act_d;
  logic                   wr_cnt, wr_ceil;
  logic [COUNT_WIDTH-1:0] cnt_d;

  assign idx      = req_i.sem_id[IdxW-1:0];
  assign bad_id   = 32'(req_i.sem_id) >= NUM_SEMAPHORES;
  assign init_val = COUNT_WIDTH'(req_i.init_count);
  assign act_cur  = active_q[idx];
  assign cnt_cur  = count_q[idx];
  assign ceil_cur = ceiling_q[idx];

  // Decide status and the entry update for the current request
  always_comb begin
    res_o.status = csem_pkg::ST_OK;
    res_o.ret_id = '0;
    res_o.wake   = 1'b0;
    wr_act       = 1'b0;
    act_d        = 1'b0;
    wr_cnt       = 1'b0;
    wr_ceil      = 1'b0;
    cnt_d        = init_val;
    if (bad_id) begin
      res_o.status = csem_pkg::ST_BAD_ID;
    end else if (req_i.mode == csem_pkg::MODE_INIT) begin
      if (act_cur) begin
        res_o.status = csem_pkg::ST_ACTIVE;
      end else begin
        wr_act       = 1'b1;
        act_d        = 1'b1;
        wr_cnt       = 1'b1;
        wr_ceil      = 1'b1;
        res_o.ret_id = req_i.sem_id[csem_pkg::RET_W-1:0];
      end
    end else if (!act_cur) begin
      res_o.status = csem_pkg::ST_INACTIVE;
    end else begin
      case (req_i.mode)
        csem_pkg::MODE_DESTROY: begin
          wr_act       = 1'b1;
          res_o.ret_id = req_i.sem_id[csem_pkg::RET_W-1:0];
        end
        csem_pkg::MODE_WAIT: begin
          if (cnt_cur == '0) begin
            res_o.status = csem_pkg::ST_BLOCK;
          end else begin
            wr_cnt       = 1'b1;
            cnt_d        = cnt_cur - 1'b1;
            res_o.ret_id = req_i.sem_id[csem_pkg::RET_W-1:0];
          end
        end
        csem_pkg::MODE_SIGNAL: begin
          if (cnt_cur >= ceil_cur) begin
            res_o.status = csem_pkg::ST_CEILING;
          end else begin
            wr_cnt     = 1'b1;
            cnt_d      = cnt_cur + 1'b1;
            res_o.wake = 1'b1;
          end
        end
        default: begin
          res_o.status = csem_pkg::ST_INACTIVE;
        end
      endcase
    end
  end

  // Active marks, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (commit_i && wr_act) begin
      active_q[idx] <= act_d;
    end
  end

  // Count and ceiling are only read for active entries, which init writes first
  always_ff @(posedge clk_i) begin
    if (commit_i && wr_cnt) begin
      count_q[idx] <= cnt_d;
    end
    if (commit_i && wr_ceil) begin
      ceiling_q[idx] <= init_val;
    end
  end

  // A successful init leaves the entry active with count equal to ceiling
  a_init_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && req_i.mode == csem_pkg::MODE_INIT && res_o.status == csem_pkg::ST_OK
    |=> active_q[$past(idx)] && count_q[$past(idx)] == ceiling_q[$past(idx)])
    else $error("init did not activate entry");

  // A successful wait takes exactly one unit
  a_wait_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && req_i.mode == csem_pkg::MODE_WAIT && res_o.status == csem_pkg::ST_OK
    |=> count_q[$past(idx)] == $past(cnt_cur) - 1'b1)
    else $error("wait did not decrement count");

  // Count never exceeds ceiling after a successful signal
  a_sig_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && res_o.wake
    |=> count_q[$past(idx)] <= ceiling_q[$past(idx)] && active_q[$past(idx)])
    else $error("signal pushed count past ceiling");

endmodule

`default_nettype wire

@@ hw/rtl/csem_out_stage.sv @@
// Result register toward the consumer.
// Depends on csem_pkg for the result type.
`default_nettype none

module csem_out_stage (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  wire csem_pkg::res_t                res_i,
  output logic                               advance_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [csem_pkg::STATUS_W-1:0]      status_o,
  output logic [csem_pkg::RET_W-1:0]         ret_id_o,
  output logic                               wake_o
);

  logic           valid_q, valid_d;
  csem_pkg::res_t res_q;

  // Register is free when empty or being drained this cycle
  assign advance_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign status_o    = res_q.status;
  assign ret_id_o    = res_q.ret_id;
  assign wake_o      = res_q.wake;

endmodule

`default_nettype wire

@@ verif/tb_counting_semaphore_table_unit.sv @@
// Self-checking testbench for counting_semaphore_table_unit: directed and random
// semaphore requests with random idling on both channels, checked against a local model.
// Depends on csem_pkg and the RTL of counting_semaphore_table_unit.
module tb_counting_semaphore_table_unit;
  import csem_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  localparam int CALM_ITEMS   = 300;   // tail of the random part without idling
  localparam int QUIET_LIMIT  = 1000;  // cycles without any transfer
  localparam int DRAIN_CYCLES = 4;

  // Tracks the semaphore bank and the outcomes still owed by the block
  class sem_outcome_tracker;
    bit [COUNT_WIDTH_DEF-1:0] counts [NUM_SEMAPHORES_DEF];
    bit [COUNT_WIDTH_DEF-1:0] ceilings [NUM_SEMAPHORES_DEF];
    bit                       live [NUM_SEMAPHORES_DEF];
    res_t                     expected_outcomes [$];
    int                       mismatches;

    // Apply one accepted request and queue its outcome
    function void note_request(mode_e op, logic [ID_W-1:0] id, logic [INIT_W-1:0] init_val);
      res_t                     res;
      int unsigned              k;
      bit [COUNT_WIDTH_DEF-1:0] start_val;
      res.status = ST_OK;
      res.ret_id = '0;
      res.wake   = 1'b0;
      k          = 32'(id);
      start_val  = init_val[COUNT_WIDTH_DEF-1:0];
      if (k >= NUM_SEMAPHORES_DEF) begin
        res.status = ST_BAD_ID;
      end else if (op == MODE_INIT) begin
        if (live[k]) begin
          res.status = ST_ACTIVE;
        end else begin
          counts[k]   = start_val;
          ceilings[k] = start_val;
          live[k]     = 1'b1;
          res.ret_id  = id[RET_W-1:0];
        end
      end else if (!live[k]) begin
        res.status = ST_INACTIVE;
      end else begin
        case (op)
          MODE_DESTROY: begin
            // count and ceiling are kept until the next init
            live[k]    = 1'b0;
            res.ret_id = id[RET_W-1:0];
          end
          MODE_WAIT: begin
            if (counts[k] == 0) begin
              res.status = ST_BLOCK;
            end else begin
              counts[k]  = counts[k] - 1'b1;
              res.ret_id = id[RET_W-1:0];
            end
          end
          default: begin
            if (counts[k] >= ceilings[k]) begin
              res.status = ST_CEILING;
            end else begin
              counts[k] = counts[k] + 1'b1;
              res.wake  = 1'b1;
            end
          end
        endcase
      end
      expected_outcomes.push_back(res);
    endfunction

    // Compare one result transfer with the oldest outcome owed
    function void check_result(logic [STATUS_W-1:0] status, logic [RET_W-1:0] ret_id,
                               logic wake);
      res_t exp_res;
      if (expected_outcomes.size() == 0) begin
        $error("result with no request outstanding: status %0d ret_id %0d wake %0d",
               status, ret_id, wake);
        mismatches++;
        return;
      end
      exp_res = expected_outcomes.pop_front();
      if (status !== exp_res.status) begin
        $error("status: expected %0d, actual %0d", exp_res.status, status);
        mismatches++;
      end
      if (ret_id !== exp_res.ret_id) begin
        $error("ret_id: expected %0d, actual %0d", exp_res.ret_id, ret_id);
        mismatches++;
      end
      if (wake !== exp_res.wake) begin
        $error("wake: expected %0d, actual %0d", exp_res.wake, wake);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic [MODE_W-1:0]   mode_i          = '0;
  logic [ID_W-1:0]     sem_id_i        = '0;
  logic [INIT_W-1:0]   initial_count_i = '0;
  logic                out_stall_i     = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [RET_W-1:0]    ret_id_o;
  logic                wake_o;

  sem_outcome_tracker tracker;
  bit                 idle_enable = 1'b1;
  int                 stall_left  = 0;
  int                 quiet_cycles = 0;

  counting_semaphore_table_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .sem_id_i       (sem_id_i),
    .initial_count_i(initial_count_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .ret_id_o       (ret_id_o),
    .wake_o         (wake_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: check each transfer, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        tracker.check_result(status_o, ret_id_o, wake_o);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left  = stall_left - 1;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  = $urandom_range(0, 7);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request, possibly after an idle burst, and wait for its transfer
  task automatic send_request(input mode_e op, input logic [ID_W-1:0] id,
                              input logic [INIT_W-1:0] cnt);
    int unsigned gap;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= op;
    sem_id_i        <= id;
    initial_count_i <= cnt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_request(op, id, cnt);
  endtask

  // Random request biased toward a few ids and small counts to hit block and ceiling
  task automatic send_random_request();
    int unsigned     pick;
    mode_e           op;
    logic [ID_W-1:0] id;
    logic [INIT_W-1:0] cnt;
    pick = $urandom_range(0, 99);
    if (pick < 20)      op = MODE_INIT;
    else if (pick < 30) op = MODE_DESTROY;
    else if (pick < 65) op = MODE_WAIT;
    else                op = MODE_SIGNAL;
    pick = $urandom_range(0, 99);
    if (pick < 70)      id = ID_W'($urandom_range(0, 7));
    else if (pick < 90) id = ID_W'($urandom_range(0, NUM_SEMAPHORES_DEF - 1));
    else                id = ID_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 60)      cnt = INIT_W'($urandom_range(0, 4));
    else if (pick < 70) cnt = '1;
    else                cnt = INIT_W'($urandom_range(0, 65535));
    send_request(op, id, cnt);
  endtask

  initial begin
    tracker = new;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Operations on entries that were never initialized
    send_request(MODE_WAIT, 8'd0, 16'h0000);
    send_request(MODE_SIGNAL, 8'd0, 16'hFFFF);
    send_request(MODE_DESTROY, 8'd0, 16'h0000);
    // Ids past the end of the bank, for every operation
    send_request(MODE_INIT, 8'd255, 16'h0001);
    send_request(MODE_WAIT, 8'd32, 16'h0000);
    send_request(MODE_SIGNAL, 8'd200, 16'h0000);
    send_request(MODE_DESTROY, 8'd128, 16'h0000);
    // Zero start value: wait blocks, signal sits at its ceiling
    send_request(MODE_INIT, 8'd0, 16'h0000);
    send_request(MODE_WAIT, 8'd0, 16'h0000);
    send_request(MODE_SIGNAL, 8'd0, 16'h0000);
    send_request(MODE_INIT, 8'd0, 16'h0005);
    send_request(MODE_DESTROY, 8'd0, 16'h0000);
    // Widest start value on the last entry
    send_request(MODE_INIT, 8'd31, 16'hFFFF);
    send_request(MODE_SIGNAL, 8'd31, 16'h0000);
    send_request(MODE_WAIT, 8'd31, 16'h0000);
    send_request(MODE_SIGNAL, 8'd31, 16'h0000);
    send_request(MODE_DESTROY, 8'd31, 16'h0000);
    send_request(MODE_WAIT, 8'd31, 16'h0000);
    send_request(MODE_INIT, 8'd31, 16'h0002);
    // Count of one: down to zero and back up to the ceiling
    send_request(MODE_INIT, 8'd5, 16'h0001);
    send_request(MODE_WAIT, 8'd5, 16'h0000);
    send_request(MODE_WAIT, 8'd5, 16'h0000);
    send_request(MODE_SIGNAL, 8'd5, 16'h0000);
    send_request(MODE_SIGNAL, 8'd5, 16'h0000);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) idle_enable = 1'b0;
      send_random_request();
    end
    in_valid_i <= 1'b0;

    while (tracker.expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/csem_pkg.sv
hw/rtl/csem_in_stage.sv
hw/rtl/csem_table.sv
hw/rtl/csem_out_stage.sv
hw/rtl/counting_semaphore_table_unit.sv
verif/tb_counting_semaphore_table_unit.sv
